// File: rtl/core/assert_macros.svh
// assertion macros used by the rtl top level, signed_int_to_decimal_ascii_core
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/sdta_pkg.sv
// types and constants of the signed integer to decimal text core
// no dependencies
package sdta_pkg;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	typedef logic [3:0] digit_t;

	// per-cycle command to the row of bcd cells
	typedef struct packed {
		logic clear;   // zero every digit
		logic dabble;  // add-3 adjust, then shift one binary bit in
		logic shift;   // move each digit one cell toward the top
	} cell_ctl_t;

	// decimal digits needed for 2^(w-1); 30103/100000 approximates log10(2)
	function automatic int digit_count(input int w);
		return ((w - 1) * 30103) / 100000 + 1;
	endfunction

endpackage

// File: rtl/core/sdta_bcd_cell.sv
// one bcd digit cell of the double-dabble row
// depends on sdta_pkg
module sdta_bcd_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sdta_pkg::cell_ctl_t ctl,
	input  logic                bit_in,
	input  sdta_pkg::digit_t    digit_in,
	output sdta_pkg::digit_t    digit,
	output logic                carry_out
);

	sdta_pkg::digit_t digit_q;
	sdta_pkg::digit_t adj;

	always_comb begin
		adj = (digit_q >= 4'd5) ? 4'(digit_q + 4'd3) : digit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctl.shift) begin
			digit_q <= digit_in;
		end
	end

	assign digit     = digit_q;
	assign carry_out = adj[3];

endmodule

// File: rtl/core/signed_int_to_decimal_ascii_core.sv
// top level: signed integer to decimal ascii text, one byte per output transfer
// depends on sdta_pkg, sdta_bcd_cell and assert_macros.svh
`include "assert_macros.svh"

// Converts one signed VALUE_WIDTH-bit integer per input transfer into its
// decimal text, one ASCII byte per output transfer: '-' for a negative value,
// then the digits of the magnitude, most significant first, no leading zeros;
// final_char marks the last byte. A row of bcd cells runs shift-add-3 once
// per magnitude bit, then shifts digits toward its top cell while the top
// digit is zero (leading zeros are dropped that way), keeping at least one
// digit. The sign, if negative, and then each digit of the top cell go to the
// output register, which holds while its byte is not taken downstream. ND is
// the number of digits of 2^(VALUE_WIDTH-1). No new input is taken until the
// last byte is loaded; a new item is taken while the last byte sits in the
// output register, even before it is taken downstream.
module signed_int_to_decimal_ascii_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic [7:0]             text_byte,
	output logic                   final_char,
	output logic                   out_valid,
	input  logic                   out_ready
);

	localparam int ND    = sdta_pkg::digit_count(VALUE_WIDTH);
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int REM_W = $clog2(ND + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_SKIP = 3'd2;
	localparam logic [2:0] S_SIGN = 3'd3;
	localparam logic [2:0] S_DIGS = 3'd4;

	logic [2:0]             state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic [7:0]             byte_q;
	logic                   final_q;
	logic                   out_valid_q;

	logic                   accept;
	logic                   load_ok;
	logic                   top_zero;
	sdta_pkg::cell_ctl_t    ctl;
	sdta_pkg::digit_t       digit_w [ND];
	logic                   carry_w [ND];

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_ok  = !out_valid_q || out_ready;
	assign top_zero = (digit_w[ND-1] == 4'd0);

	always_comb begin
		ctl.clear  = accept;
		ctl.dabble = (state_q == S_CONV);
		ctl.shift  = ((state_q == S_SKIP) && top_zero && (rem_q > REM_W'(1)))
			|| ((state_q == S_DIGS) && load_ok);
	end

	for (genvar i = 0; i < ND; i++) begin : g_cell
		sdta_bcd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.bit_in    ((i == 0) ? mag_q[VALUE_WIDTH-1] : carry_w[(i == 0) ? 0 : i-1]),
			.digit_in  ((i == 0) ? 4'd0 : digit_w[(i == 0) ? 0 : i-1]),
			.digit     (digit_w[i]),
			.carry_out (carry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						neg_q   <= value[VALUE_WIDTH-1];
						cnt_q   <= CNT_W'(VALUE_WIDTH);
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						rem_q   <= REM_W'(ND);
						state_q <= S_SKIP;
					end
				end
				S_SKIP: begin
					if (top_zero && (rem_q > REM_W'(1))) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= neg_q ? S_SIGN : S_DIGS;
					end
				end
				S_SIGN: begin
					if (load_ok) begin
						state_q <= S_DIGS;
					end
				end
				S_DIGS: begin
					if (load_ok) begin
						rem_q <= rem_q - REM_W'(1);
						if (rem_q == REM_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// magnitude as unsigned, so the most negative value needs no special case
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~value + 1'b1) : value;
		end else if (state_q == S_CONV) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	// output register parts the converter from the downstream side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == S_SIGN) || (state_q == S_DIGS)) && load_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_SIGN) && load_ok) begin
			byte_q  <= sdta_pkg::ASCII_MINUS;
			final_q <= 1'b0;
		end else if ((state_q == S_DIGS) && load_ok) begin
			byte_q  <= sdta_pkg::ASCII_ZERO + {4'd0, digit_w[ND-1]};
			final_q <= (rem_q == REM_W'(1));
		end
	end

	assign text_byte  = byte_q;
	assign final_char = final_q;
	assign out_valid  = out_valid_q;

	// the top cell never overflows during conversion
	`ASSERT_SAME(a_no_overflow, clk, arst_n, state_q == S_CONV, !carry_w[ND-1])
	// the top digit stays a decimal digit
	`ASSERT_SAME(a_top_digit, clk, arst_n, 1'b1, digit_w[ND-1] <= 4'd9)
	// a transfer in starts the conversion
	`ASSERT_NEXT(a_start, clk, arst_n, accept, (state_q == S_CONV) && (cnt_q != '0))
	// digits are emitted only while some remain
	`ASSERT_SAME(a_rem, clk, arst_n, state_q == S_DIGS, rem_q != '0)

endmodule

// File: tb/tb_signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 100ps
// testbench for signed_int_to_decimal_ascii_core: drives integers and checks every text byte
// depends on sdta_pkg and the core; expected text is predicted from each accepted value
module tb_signed_int_to_decimal_ascii_core;

	localparam int VALUE_WIDTH   = 32;
	localparam int ITEMS_PER_PHASE = 32;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 100;
	localparam int MAX_REPORTS   = 10;

	typedef enum int {
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} idle_phase_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [VALUE_WIDTH-1:0] value = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [7:0]             text_byte;
	logic                   final_char;
	logic                   out_valid;
	logic                   out_ready = 1'b0;

	logic [VALUE_WIDTH-1:0] pending_values [$];
	text_char_t             expected_text [$];
	idle_phase_t            phase = PH_FREE;
	int                     failures = 0;
	int                     quiet_cycles = 0;

	signed_int_to_decimal_ascii_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_byte (text_byte),
		.final_char(final_char),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	always #1 clk = ~clk;

	// decimal text of a two's complement value, pushed one char per expected transfer
	function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v);
		logic [VALUE_WIDTH-1:0] mag;
		logic [3:0]             digits [0:19];
		int                     n;
		text_char_t             c;
		mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
		n = 0;
		do begin
			digits[n] = 4'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0);
		if (v[VALUE_WIDTH-1]) begin
			c.ch = sdta_pkg::ASCII_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		for (int i = n - 1; i >= 0; i--) begin
			c.ch = sdta_pkg::ASCII_ZERO + 8'(digits[i]);
			c.last = (i == 0);
			expected_text.push_back(c);
		end
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] random_value();
		logic [VALUE_WIDTH-1:0] p;
		int                     k;
		case ($urandom_range(5))
			0, 1: return $urandom;
			2: begin
				p = $urandom_range(999);
				return $urandom_range(1) ? -p : p;
			end
			3: begin
				// around a power of ten, where the digit count changes
				p = 1;
				k = $urandom_range(9);
				repeat (k) p = p * 10;
				p = p + $urandom_range(2) - 1;
				return $urandom_range(1) ? -p : p;
			end
			4: begin
				case ($urandom_range(3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h8000_0001;
					default: return '0;
				endcase
			end
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	function automatic int idle_percent(input logic sender);
		if (phase == PH_BOTH)
			return 18;
		if (sender)
			return (phase == PH_SEND_IDLE) ? 49 : 0;
		return (phase == PH_RECV_STALL) ? 49 : 0;
	endfunction

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $time, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		logic gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_text(value);
			if (!in_valid || in_ready) begin
				gap = ($urandom_range(99) < idle_percent(1'b1));
				if (pending_values.size() > 0 && !gap) begin
					in_valid <= 1'b1;
					value <= pending_values.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		text_char_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_text.size() == 0) begin
					note_failure($sformatf("unexpected transfer: byte %0d final %0b",
						text_byte, final_char));
				end else begin
					want = expected_text.pop_front();
					if (text_byte !== want.ch || final_char !== want.last)
						note_failure($sformatf("expected byte %0d final %0b, got byte %0d final %0b",
							want.ch, want.last, text_byte, final_char));
				end
			end
			out_ready <= ($urandom_range(99) >= idle_percent(1'b0));
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero, sign boundaries, digit-count boundaries, most negative value
		pending_values.push_back(32'd0);
		pending_values.push_back(32'd1);
		pending_values.push_back(-32'd1);
		pending_values.push_back(32'd9);
		pending_values.push_back(32'd10);
		pending_values.push_back(-32'd10);
		pending_values.push_back(32'd99);
		pending_values.push_back(32'd100);
		pending_values.push_back(-32'd9);
		pending_values.push_back(32'h7fff_ffff);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h8000_0001);
		pending_values.push_back(32'd1000000000);
		pending_values.push_back(32'd999999999);
		pending_values.push_back(-32'd999999999);
		pending_values.push_back(-32'd1000000000);
		pending_values.push_back(32'd1234567890);
		pending_values.push_back(-32'd1234567890);
		pending_values.push_back(32'h5555_5555);
		pending_values.push_back(32'haaaa_aaaa);

		for (int p = PH_FREE; p <= PH_BOTH; p++) begin
			phase = idle_phase_t'(p);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				pending_values.push_back(random_value());
			while (pending_values.size() > 0 || in_valid || expected_text.size() > 0)
				@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0 && expected_text.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sdta_pkg.sv
rtl/core/sdta_bcd_cell.sv
rtl/core/signed_int_to_decimal_ascii_core.sv
tb/tb_signed_int_to_decimal_ascii_core.sv
